// ===== design/fdm_pkg.sv =====
// fdm_pkg: shared constants for the frame drop monitor.
// Register indexes, reset values and loss status codes.
// No dependencies.
package fdm_pkg;

  typedef enum logic [2:0] {
    REG_CYCLE_TIME  = 3'd0,
    REG_LATE_FACTOR = 3'd1,
    REG_MULTI_LOSS  = 3'd2,
    REG_DISCONNECT  = 3'd3,
    REG_HOLDOFF     = 3'd4,
    REG_WARMUP      = 3'd5,
    REG_SENSOR_EN   = 3'd6,
    REG_ALARM_EN    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    LOSS_NONE       = 2'd0,
    LOSS_ONE        = 2'd1,
    LOSS_MULTIPLE   = 2'd2,
    LOSS_DISCONNECT = 2'd3
  } loss_t;

  localparam logic [7:0]  RST_CYCLE_TIME  = 8'd12;
  localparam logic [7:0]  RST_LATE_FACTOR = 8'd24;
  localparam logic [7:0]  RST_MULTI_LOSS  = 8'd2;
  localparam logic [15:0] RST_DISCONNECT  = 16'd1000;
  localparam logic [15:0] RST_HOLDOFF     = 16'd5000;
  localparam logic [15:0] RST_WARMUP      = 16'd100;
  localparam int          RATE_SCALE      = 256000;
  localparam logic [15:0] SAT16           = 16'hFFFF;

endpackage

// ===== design/fdm_ram.sv =====
// fdm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fdm_div.sv =====
// fdm_div: shared restoring divider, one quotient bit per cycle.
// No dependencies.
module fdm_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r, quo_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CW'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= DEN_W'(trial - {1'b0, den_r});
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[DEN_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== design/frame_drop_monitor.sv =====
// frame_drop_monitor: control loop health monitor, top level.
// Uses fdm_pkg, fdm_ram (interval window) and fdm_div (shared divider).
//
// Usage:
//  in_*  : one item per control frame (system time, frame time, sensor words).
//          An item with a zero frame time is taken and gives no result.
//  out_* : one result item per item with nonzero frame time: frame rate,
//          average/min/max interval, dropped frames, loss status, alarm.
//  cfg_* : register writes, index and data; always ready. Write only idle.
// Sequence: the interval scan reads the window RAM one entry at a time, with
//  a read state and a compare state per entry; the one divider then runs
//  three divisions in turn. NUM_W is the divider width (32 by default) and
//  the window holds 16 entries by default.
// Throughput: one item at a time; in_ready is low from acceptance until the
//  result is placed in the output register.
// Reset: window empty, all history and alarm state zero, registers at their
//  reset values; no clearing pass is needed.
// Stall: a result waits in the output register; a finished item waits for a
//  free output register before its frame, sensor and alarm history update.
module frame_drop_monitor import fdm_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  parameter int TIME_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TIME_BITS-1:0] in_system_time_ms,
  input  logic [TIME_BITS-1:0] in_frame_time_ms,
  input  logic signed [15:0]   in_accel_x,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  input  logic signed [15:0]   in_gyro_x,
  input  logic signed [15:0]   in_gyro_y,
  input  logic signed [15:0]   in_gyro_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_frame_rate_q8,
  output logic [15:0]          out_avg_interval_ms,
  output logic [15:0]          out_max_interval_ms,
  output logic [15:0]          out_min_interval_ms,
  output logic [15:0]          out_frames_dropped,
  output logic [1:0]           out_loss_status,
  output logic                 out_disconnect_alarm
);

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = 16 + $clog2(WINDOW_DEPTH);
  localparam int RNUM_W = FILL_W + 19;
  localparam int NUM_W  = (TIME_BITS > RNUM_W) ? TIME_BITS : RNUM_W;
  localparam int DEN_W  = SUM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_PUSH, S_SCAN_RD, S_SCAN_CMP, S_DIV_GO, S_DIV_WAIT, S_FIN
  } state_t;

  typedef enum logic [1:0] {OP_AVG, OP_RATE, OP_DROP} div_op_t;

  state_t  state_r;
  div_op_t op_r;

  logic [7:0]  cycle_time_r, late_factor_r, multi_loss_r;
  logic [15:0] disconnect_r, holdoff_r, warmup_frames_r;
  logic        sensor_en_r, alarm_en_r;

  logic [TIME_BITS-1:0] now_r, ft_r, last_exec_r, last_frame_r, alarm_stamp_r, delta_r;
  logic [47:0]          acc_r, gyr_r, last_acc_r, last_gyr_r;
  logic [FILL_W-1:0]    fill_r, idx_r;
  logic [AW-1:0]        head_r;
  logic [SUM_W-1:0]     sum_r;
  logic [16:0]          warmup_r;
  logic [15:0]          mx_r, mn_r, avg_r, rate_r;
  logic                 lft_nz_r;

  logic                 out_valid_r;
  logic [15:0]          o_rate_r, o_avg_r, o_max_r, o_min_r, o_drop_r;
  logic [1:0]           o_status_r;
  logic                 o_alarm_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [15:0]          ram_rdata;
  logic [TIME_BITS-1:0] iv_diff;
  logic [15:0]          iv_sat;
  logic                 full;

  logic                 div_start, div_done;
  logic [NUM_W-1:0]     div_num, div_quo;
  logic [DEN_W-1:0]     div_den, div_rem;

  logic [TIME_BITS-1:0] lft_eff;
  logic [NUM_W:0]       q1, qs, nq;
  logic [15:0]          dropped;
  logic [11:0]          thr;
  logic                 late, sens, round_up;
  logic [1:0]           status;
  logic                 alarm;
  logic [TIME_BITS-1:0] stamp_d;
  logic [23:0]          drop_prod;
  logic                 out_free;

  assign full      = (fill_r == FILL_W'(WINDOW_DEPTH));
  assign iv_diff   = now_r - last_exec_r;
  assign iv_sat    = (iv_diff > TIME_BITS'(SAT16)) ? SAT16 : iv_diff[15:0];
  assign ram_we    = (state_r == S_PUSH) && (last_exec_r != '0);
  assign ram_raddr = (state_r == S_PREP) ? head_r : idx_r[AW-1:0];
  assign lft_eff   = (last_frame_r > ft_r) ? ft_r : last_frame_r;
  assign out_free  = !out_valid_r || out_ready;

  fdm_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (iv_sat),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    div_start = (state_r == S_DIV_GO);
    case (op_r)
      OP_AVG: begin
        div_num = NUM_W'(sum_r);
        div_den = (fill_r == '0) ? DEN_W'(1) : DEN_W'(fill_r);
      end
      OP_RATE: begin
        div_num = NUM_W'(NUM_W'(fill_r) * NUM_W'(RATE_SCALE)) + NUM_W'(sum_r >> 1);
        div_den = (sum_r == '0) ? DEN_W'(1) : sum_r;
      end
      OP_DROP: begin
        div_num = NUM_W'(delta_r);
        div_den = (cycle_time_r == '0) ? DEN_W'(1) : DEN_W'(cycle_time_r);
      end
      default: begin
        div_num = '0;
        div_den = DEN_W'(1);
      end
    endcase
  end

  fdm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    round_up  = ({1'b0, div_rem} << 1) >= (DEN_W + 1)'((cycle_time_r == '0) ? 8'd1
                                                                            : cycle_time_r);
    q1        = {1'b0, div_quo} + (NUM_W + 1)'(round_up);
    qs        = (q1 < (NUM_W + 1)'(2)) ? (NUM_W + 1)'(2) : q1;
    nq        = qs - 1'b1;
    thr       = 12'((16'(late_factor_r) * 16'(cycle_time_r)) >> 4);
    late      = delta_r > TIME_BITS'(thr);
    sens      = sensor_en_r && (acc_r != last_acc_r) && (gyr_r != last_gyr_r);
    dropped   = (late || sens) ? ((nq > (NUM_W + 1)'(SAT16)) ? SAT16 : nq[15:0]) : 16'd0;
    drop_prod = 24'(dropped) * 24'(cycle_time_r);
    stamp_d   = ft_r - alarm_stamp_r;
    status    = LOSS_NONE;
    alarm     = 1'b0;
    if (lft_nz_r && dropped != '0) begin
      status = LOSS_ONE;
      if (dropped >= 16'(multi_loss_r)) status = LOSS_MULTIPLE;
      if (drop_prod > 24'(disconnect_r)) begin
        status = LOSS_DISCONNECT;
        alarm  = alarm_en_r && !stamp_d[TIME_BITS-1] &&
                 (stamp_d > TIME_BITS'(holdoff_r)) && (warmup_r > 17'(warmup_frames_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      op_r            <= OP_AVG;
      cycle_time_r    <= RST_CYCLE_TIME;
      late_factor_r   <= RST_LATE_FACTOR;
      multi_loss_r    <= RST_MULTI_LOSS;
      disconnect_r    <= RST_DISCONNECT;
      holdoff_r       <= RST_HOLDOFF;
      warmup_frames_r <= RST_WARMUP;
      sensor_en_r     <= 1'b1;
      alarm_en_r      <= 1'b1;
      fill_r          <= '0;
      head_r          <= '0;
      sum_r           <= '0;
      last_exec_r     <= '0;
      last_frame_r    <= '0;
      last_acc_r      <= '0;
      last_gyr_r      <= '0;
      alarm_stamp_r   <= '0;
      warmup_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CYCLE_TIME:  cycle_time_r    <= cfg_data[7:0];
          REG_LATE_FACTOR: late_factor_r   <= cfg_data[7:0];
          REG_MULTI_LOSS:  multi_loss_r    <= cfg_data[7:0];
          REG_DISCONNECT:  disconnect_r    <= cfg_data;
          REG_HOLDOFF:     holdoff_r       <= cfg_data;
          REG_WARMUP:      warmup_frames_r <= cfg_data;
          REG_SENSOR_EN:   sensor_en_r     <= cfg_data[0];
          REG_ALARM_EN:    alarm_en_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && !(state_r == S_FIN)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_frame_time_ms != '0) begin
            now_r   <= in_system_time_ms;
            ft_r    <= in_frame_time_ms;
            acc_r   <= {in_accel_x, in_accel_y, in_accel_z};
            gyr_r   <= {in_gyro_x, in_gyro_y, in_gyro_z};
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          delta_r  <= ft_r - lft_eff;
          lft_nz_r <= (lft_eff != '0);
          state_r  <= S_PUSH;
        end
        S_PUSH: begin
          if (last_exec_r != '0) begin
            sum_r  <= sum_r - (full ? SUM_W'(ram_rdata) : SUM_W'(0)) + SUM_W'(iv_sat);
            if (!full) fill_r <= fill_r + 1'b1;
            head_r <= (head_r == AW'(WINDOW_DEPTH - 1)) ? AW'(0) : head_r + 1'b1;
          end
          last_exec_r <= now_r;
          mx_r        <= '0;
          mn_r        <= SAT16;
          idx_r       <= '0;
          state_r     <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (idx_r == fill_r) begin
            op_r    <= OP_AVG;
            state_r <= S_DIV_GO;
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (ram_rdata > mx_r) mx_r <= ram_rdata;
          if (ram_rdata < mn_r) mn_r <= ram_rdata;
          idx_r   <= idx_r + 1'b1;
          state_r <= S_SCAN_RD;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (op_r)
              OP_AVG: begin
                avg_r   <= div_quo[15:0];
                op_r    <= OP_RATE;
                state_r <= S_DIV_GO;
              end
              OP_RATE: begin
                rate_r  <= (div_quo > NUM_W'(SAT16)) ? SAT16 : div_quo[15:0];
                op_r    <= OP_DROP;
                state_r <= S_DIV_GO;
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_rate_r    <= (fill_r == '0 || sum_r == '0) ? 16'd0 : rate_r;
            o_avg_r     <= (fill_r == '0) ? 16'd0 : avg_r;
            o_max_r     <= (fill_r == '0) ? 16'd0 : mx_r;
            o_min_r     <= (fill_r == '0) ? 16'd0 : mn_r;
            o_drop_r    <= lft_nz_r ? dropped : 16'd0;
            o_status_r  <= status;
            o_alarm_r   <= alarm;
            if (lft_nz_r) begin
              last_acc_r <= acc_r;
              last_gyr_r <= gyr_r;
            end
            if (alarm) alarm_stamp_r <= ft_r;
            last_frame_r <= ft_r;
            if (!(warmup_r > 17'(warmup_frames_r))) warmup_r <= warmup_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready            = 1'b1;
  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_frame_rate_q8    = o_rate_r;
  assign out_avg_interval_ms  = o_avg_r;
  assign out_max_interval_ms  = o_max_r;
  assign out_min_interval_ms  = o_min_r;
  assign out_frames_dropped   = o_drop_r;
  assign out_loss_status      = o_status_r;
  assign out_disconnect_alarm = o_alarm_r;

endmodule

// ===== design/fdm_checker.sv =====
// fdm_checker: port-level checks for frame_drop_monitor, bound to the top level.
// Uses fdm_pkg for loss status codes.
module fdm_checker import fdm_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [TIME_BITS-1:0] in_frame_time_ms,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [15:0]          out_frame_rate_q8,
  input logic [15:0]          out_avg_interval_ms,
  input logic [15:0]          out_max_interval_ms,
  input logic [15:0]          out_min_interval_ms,
  input logic [15:0]          out_frames_dropped,
  input logic [1:0]           out_loss_status,
  input logic                 out_disconnect_alarm
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frames_dropped) &&
    $stable(out_loss_status) && $stable(out_frame_rate_q8))
    else $error("result item changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_time_ms != '0 |=> !in_ready)
    else $error("ready while an item is in work");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_loss_status == LOSS_NONE) == (out_frames_dropped == 16'd0)))
    else $error("loss status disagrees with dropped count");

  a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_disconnect_alarm |-> out_loss_status == LOSS_DISCONNECT)
    else $error("alarm without disconnect status");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_interval_ms <= out_avg_interval_ms &&
                  out_avg_interval_ms <= out_max_interval_ms)
    else $error("average outside min and max");

endmodule

bind frame_drop_monitor fdm_checker #(.TIME_BITS(TIME_BITS)) u_fdm_checker (.*);

// ===== dv/tb_frame_drop_monitor.sv =====
// tb_frame_drop_monitor: self-checking testbench for frame_drop_monitor.
// Drives frames through a queue-fed driver, predicts results in-line, checks them.
// Depends on fdm_pkg and the frame_drop_monitor RTL.
`timescale 1ns / 100ps

module tb_frame_drop_monitor;
  import fdm_pkg::*;

  typedef struct {
    logic        hold_drain;
    logic [31:0] sys_t;
    logic [31:0] frm_t;
    logic [15:0] ax, ay, az, gx, gy, gz;
  } frame_t;

  typedef struct {
    logic [15:0] rate;
    logic [15:0] avg;
    logic [15:0] mx;
    logic [15:0] mn;
    logic [15:0] dropped;
    logic [1:0]  status;
    logic        alarm;
  } health_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [31:0] in_system_time_ms = '0;
  logic [31:0] in_frame_time_ms = '0;
  logic signed [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [15:0] in_gyro_x = '0, in_gyro_y = '0, in_gyro_z = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_frame_rate_q8, out_avg_interval_ms, out_max_interval_ms;
  logic [15:0] out_min_interval_ms, out_frames_dropped;
  logic [1:0] out_loss_status;
  logic out_disconnect_alarm;

  frame_drop_monitor DUT (.*);

  always #5 clk = ~clk;

  frame_t  frame_q[$];
  health_t health_q[$];
  int      errors = 0;
  int      idle_mode = 2;

  // predictor copy of registers and history
  logic [7:0]  p_cycle, p_late, p_multi;
  logic [15:0] p_disc, p_holdoff, p_warmup;
  logic        p_sens_en, p_alarm_en;
  logic [15:0] win[16];
  int unsigned win_fill, win_head, win_sum;
  logic [31:0] last_exec, last_frm, alarm_stamp;
  logic [47:0] last_acc, last_gyr;
  int unsigned warm_cnt;

  function automatic void track_health(frame_t f);
    health_t h;
    longint unsigned delta, cyc, thr, q, r, n, d;
    logic [47:0] acc, gyr;
    logic late, sens;
    logic [15:0] v;
    h = '{default: '0};
    if (f.frm_t == 0) return;
    if (last_exec != 0) begin
      d = 32'(f.sys_t - last_exec);
      v = (d > 65535) ? 16'hFFFF : d[15:0];
      if (win_fill >= 16) win_sum -= win[win_head];
      else win_fill++;
      win[win_head] = v;
      win_sum += v;
      win_head = (win_head + 1) % 16;
    end
    last_exec = f.sys_t;
    if (win_fill != 0) begin
      h.mn = 16'hFFFF;
      for (int i = 0; i < win_fill; i++) begin
        if (win[i] > h.mx) h.mx = win[i];
        if (win[i] < h.mn) h.mn = win[i];
      end
      h.avg = win_sum / win_fill;
      if (win_sum != 0) begin
        q = (longint'(win_fill) * 256000 + win_sum / 2) / win_sum;
        h.rate = (q > 65535) ? 16'hFFFF : q[15:0];
      end
    end
    acc = {f.ax, f.ay, f.az};
    gyr = {f.gx, f.gy, f.gz};
    if (last_frm > f.frm_t) last_frm = f.frm_t;
    if (last_frm != 0) begin
      delta = f.frm_t - last_frm;
      cyc = (p_cycle != 0) ? p_cycle : 1;
      thr = (longint'(p_late) * p_cycle) >> 4;
      late = delta > thr;
      sens = p_sens_en && acc != last_acc && gyr != last_gyr;
      last_acc = acc;
      last_gyr = gyr;
      q = delta / cyc;
      r = delta % cyc;
      if (2 * r >= cyc) q++;
      if (q < 2) q = 2;
      n = q - 1;
      if (n > 65535) n = 65535;
      h.dropped = (late || sens) ? n[15:0] : 16'd0;
      if (h.dropped != 0) begin
        h.status = LOSS_ONE;
        if (h.dropped >= p_multi) h.status = LOSS_MULTIPLE;
        if (longint'(h.dropped) * p_cycle > p_disc) begin
          d = 32'(f.frm_t - alarm_stamp);
          h.status = LOSS_DISCONNECT;
          if (p_alarm_en && !d[31] && d > p_holdoff && warm_cnt > p_warmup) begin
            alarm_stamp = f.frm_t;
            h.alarm = 1;
          end
        end
      end
    end
    last_frm = f.frm_t;
    if (!(warm_cnt > p_warmup)) warm_cnt++;
    health_q.push_back(h);
  endfunction

  // register writes into the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      p_cycle <= RST_CYCLE_TIME;
      p_late <= RST_LATE_FACTOR;
      p_multi <= RST_MULTI_LOSS;
      p_disc <= RST_DISCONNECT;
      p_holdoff <= RST_HOLDOFF;
      p_warmup <= RST_WARMUP;
      p_sens_en <= 1'b1;
      p_alarm_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CYCLE_TIME:  p_cycle <= cfg_data[7:0];
        REG_LATE_FACTOR: p_late <= cfg_data[7:0];
        REG_MULTI_LOSS:  p_multi <= cfg_data[7:0];
        REG_DISCONNECT:  p_disc <= cfg_data;
        REG_HOLDOFF:     p_holdoff <= cfg_data;
        REG_WARMUP:      p_warmup <= cfg_data;
        REG_SENSOR_EN:   p_sens_en <= cfg_data[0];
        REG_ALARM_EN:    p_alarm_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      win_fill = 0; win_head = 0; win_sum = 0;
      last_exec = 0; last_frm = 0; alarm_stamp = 0;
      last_acc = 0; last_gyr = 0; warm_cnt = 0;
    end else begin
      if (in_valid && in_ready)
        track_health('{1'b0, in_system_time_ms, in_frame_time_ms, in_accel_x,
                       in_accel_y, in_accel_z, in_gyro_x, in_gyro_y, in_gyro_z});
      if (!in_valid || in_ready) begin
        if (frame_q.size() != 0 && frame_q[0].hold_drain) begin
          if (health_q.size() == 0) void'(frame_q.pop_front());
          in_valid <= 1'b0;
        end else if (frame_q.size() != 0 &&
                     !(idle_mode == 0 && $urandom_range(99) < 14) &&
                     !(idle_mode == 1 && $urandom_range(99) < 60)) begin
          in_valid <= 1'b1;
          in_system_time_ms <= frame_q[0].sys_t;
          in_frame_time_ms <= frame_q[0].frm_t;
          in_accel_x <= frame_q[0].ax;
          in_accel_y <= frame_q[0].ay;
          in_accel_z <= frame_q[0].az;
          in_gyro_x <= frame_q[0].gx;
          in_gyro_y <= frame_q[0].gy;
          in_gyro_z <= frame_q[0].gz;
          void'(frame_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    health_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (health_q.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          e = health_q.pop_front();
          if (out_frame_rate_q8 !== e.rate) begin
            $error("frame_rate_q8 exp %0d got %0d", e.rate, out_frame_rate_q8); errors++;
          end
          if (out_avg_interval_ms !== e.avg) begin
            $error("avg_interval_ms exp %0d got %0d", e.avg, out_avg_interval_ms); errors++;
          end
          if (out_max_interval_ms !== e.mx) begin
            $error("max_interval_ms exp %0d got %0d", e.mx, out_max_interval_ms); errors++;
          end
          if (out_min_interval_ms !== e.mn) begin
            $error("min_interval_ms exp %0d got %0d", e.mn, out_min_interval_ms); errors++;
          end
          if (out_frames_dropped !== e.dropped) begin
            $error("frames_dropped exp %0d got %0d", e.dropped, out_frames_dropped);
            errors++;
          end
          if (out_loss_status !== e.status) begin
            $error("loss_status exp %0d got %0d", e.status, out_loss_status); errors++;
          end
          if (out_disconnect_alarm !== e.alarm) begin
            $error("disconnect_alarm exp %0d got %0d", e.alarm, out_disconnect_alarm);
            errors++;
          end
        end
      end
      case (idle_mode)
        0: out_ready <= ($urandom_range(99) >= 60);
        1: out_ready <= ($urandom_range(99) >= 14);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  logic [31:0] sys_now, frm_now;
  logic [15:0] snap[6];

  task automatic add_frame(logic [31:0] st, logic [31:0] ft, logic [15:0] s[6]);
    frame_q.push_back('{1'b0, st, ft, s[0], s[1], s[2], s[3], s[4], s[5]});
  endtask

  task automatic add_random_frame();
    int k;
    k = $urandom_range(99);
    sys_now += (k < 5) ? $urandom : (k < 8) ? -$urandom_range(500) :
               12 + $urandom_range(8) - 3;
    k = $urandom_range(99);
    if (k < 3) frm_now = $urandom;
    else if (k < 8) frm_now -= $urandom_range(3000);
    else if (k < 20) frm_now += 12 * $urandom_range(15, 2);
    else if (k < 25) frm_now += $urandom_range(200000);
    else frm_now += $urandom_range(14, 10);
    k = $urandom_range(99);
    if (k >= 50) snap[$urandom_range(2)] = 16'($urandom);
    if (k >= 75) snap[3 + $urandom_range(2)] = 16'($urandom);
    if ($urandom_range(99) < 3) add_frame($urandom, 0, snap);
    else add_frame(sys_now, frm_now, snap);
  endtask

  task automatic set_reg(reg_idx_t idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] v[8]);
    wait (frame_q.size() == 0 && !in_valid && health_q.size() == 0);
    repeat (200) @(posedge clk);
    for (int i = 0; i < 8; i++) set_reg(reg_idx_t'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int mode, int count);
    idle_mode = mode;
    for (int i = 0; i < count; i++) begin
      add_random_frame();
      if (i == count / 2) frame_q.push_back('{hold_drain: 1'b1, default: '0});
    end
  endtask

  initial begin
    logic [15:0] s0[6], s1[6];
    s0 = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
    s1 = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    idle_mode = 2;
    add_frame(32'd5, 32'd0, s1);
    add_frame(32'd0, 32'd100, s0);
    add_frame(32'd1, 32'd112, s0);
    add_frame(32'd1, 32'd124, s1);
    add_frame(32'd13, 32'd160, s1);
    add_frame(32'd25, 32'd50, s0);
    add_frame(32'hFFFF_FFF0, 32'd62, s1);
    add_frame(32'd5, 32'd74, s1);
    add_frame(32'd17, 32'hFFFF_FFFF, s0);
    add_frame(32'd29, 32'hFFFF_FFFF, s1);
    add_frame(32'hFFFF_FFFF, 32'h8000_0000, s0);
    add_frame(32'h7FFF_FFFF, 32'h8000_000C, s0);
    for (int i = 0; i < 8; i++) add_frame(32'h7FFF_FFFF + 12 * i, 32'h8000_0018 + 12 * i, s0);
    sys_now = 32'h8000_1000;
    frm_now = 32'h8000_1000;
    snap = s0;
    run_phase(0, 60);
    load_regs('{16'hFFFF, 16'd0, 16'd255, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
    run_phase(0, 110);
    load_regs('{16'd0, 16'd255, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0});
    run_phase(1, 110);
    load_regs('{16'd1, 16'd16, 16'd1, 16'd40, 16'd0, 16'd3, 16'd0, 16'd1});
    run_phase(1, 110);
    load_regs('{16'(8 + $urandom_range(20)), 16'($urandom_range(255)),
                16'($urandom_range(4, 1)), 16'($urandom_range(300)),
                16'($urandom_range(2000)), 16'($urandom_range(30)),
                16'($urandom_range(1)), 16'd1});
    run_phase(2, 110);
    wait (frame_q.size() == 0 && !in_valid && health_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && health_q.size() == 0) begin
      $display("frame_drop_monitor test passed");
    end else begin
      $display("frame_drop_monitor test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("frame_drop_monitor test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fdm_pkg.sv
design/fdm_ram.sv
design/fdm_div.sv
design/frame_drop_monitor.sv
design/fdm_checker.sv
dv/tb_frame_drop_monitor.sv
